// ===== rtl/pnig_pkg.sv =====
package pnig_pkg;

    // geometry limits
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = 24;
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int MAX_DIM    = 1 << COORD_BITS;
    localparam int CL_W       = (CFG_DIM_W > DIM_W) ? CFG_DIM_W : DIM_W;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int CMP_W      = (AREA_W > IDX_BITS) ? AREA_W : IDX_BITS;

    // radix-4 restoring divider
    localparam int DIV_STEPS  = (COORD_BITS + 1) / 2;
    localparam int QUO_W      = 2 * DIV_STEPS;
    localparam int DVS_W      = DIM_W + QUO_W - 1;
    localparam int DIV_W      = (DVS_W > IDX_BITS) ? DVS_W : IDX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // neighbor candidates and queue
    localparam int NB_COUNT   = 14;
    localparam int NB_SEL_W   = $clog2(NB_COUNT);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WRAP   = 2'd2,
        CFG_EIGHT  = 2'd3
    } t_cfg_reg;

    // candidate neighbors in emission order
    typedef enum logic [NB_SEL_W-1:0] {
        NB_LEFT, NB_RIGHT, NB_UP, NB_DOWN, NB_FIRST, NB_LAST,
        NB_UL, NB_DL, NB_UR, NB_DR, NB_FU, NB_FD, NB_LU, NB_LD
    } t_nb;

    typedef enum logic [1:0] {
        PX_ZERO,
        PX_INC,
        PX_DEC
    } t_px;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_CLASS
    } t_front_state;

    // offset of a neighbor: +-(w_mag * width) plus a column step
    typedef struct packed {
        logic [1:0] w_mag;
        logic       w_neg;
        t_px        px;
    } t_nb_ofs;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
        logic              wrap;
        logic              eight;
    } t_geom;

    typedef struct packed {
        logic [IDX_BITS-1:0] pix;
        logic [NB_COUNT-1:0] mask;
    } t_item;

    // saturate a written dimension to the coordinate range
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
        logic [CL_W-1:0] de;
        logic [CL_W-1:0] lim;
        de  = CL_W'(d);
        lim = CL_W'(MAX_DIM);
        return (de > lim) ? DIM_W'(lim) : DIM_W'(de);
    endfunction

    // offset table of the neighbor candidates
    function automatic t_nb_ofs nb_offset(input t_nb k);
        t_nb_ofs o;
        unique case (k)
            NB_LEFT:  o = '{2'd0, 1'b0, PX_DEC};
            NB_RIGHT: o = '{2'd0, 1'b0, PX_INC};
            NB_UP:    o = '{2'd1, 1'b1, PX_ZERO};
            NB_DOWN:  o = '{2'd1, 1'b0, PX_ZERO};
            NB_FIRST: o = '{2'd1, 1'b0, PX_DEC};
            NB_LAST:  o = '{2'd1, 1'b1, PX_INC};
            NB_UL:    o = '{2'd1, 1'b1, PX_DEC};
            NB_DL:    o = '{2'd1, 1'b0, PX_DEC};
            NB_UR:    o = '{2'd1, 1'b1, PX_INC};
            NB_DR:    o = '{2'd1, 1'b0, PX_INC};
            NB_FU:    o = '{2'd0, 1'b0, PX_DEC};
            NB_FD:    o = '{2'd2, 1'b0, PX_DEC};
            NB_LU:    o = '{2'd2, 1'b1, PX_INC};
            NB_LD:    o = '{2'd0, 1'b0, PX_INC};
            default:  o = '{2'd0, 1'b0, PX_ZERO};
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/pnig_front.sv =====
module pnig_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pnig_pkg::t_geom                 i_geom,
    input  logic                            i_s_valid,
    output logic                            o_s_ready,
    input  logic [pnig_pkg::IDX_BITS-1:0]   i_s_pix,
    output logic                            o_q_valid,
    input  logic                            i_q_ready,
    output pnig_pkg::t_item                 o_q_item
);

    pnig_pkg::t_front_state r_state, n_state;

    logic                              r_in_valid;
    logic [pnig_pkg::IDX_BITS-1:0]     r_in_pix;
    logic [pnig_pkg::IDX_BITS-1:0]     r_pix;
    logic [pnig_pkg::DIV_W-1:0]        r_rem;
    logic [pnig_pkg::DIV_W-1:0]        r_dvs;
    logic [pnig_pkg::QUO_W-1:0]        r_quo;
    logic [pnig_pkg::STEP_W-1:0]       r_step;

    logic                              in_frame;
    logic                              start;
    logic                              take;
    logic                              div_last;
    logic [pnig_pkg::DIV_W-1:0]        dvs_half;
    logic [pnig_pkg::DIV_W-1:0]        rem1;
    logic [pnig_pkg::DIV_W-1:0]        rem2;
    logic                              ge1;
    logic                              ge2;
    logic [pnig_pkg::COORD_BITS-1:0]   col;
    logic [pnig_pkg::COORD_BITS-1:0]   row;
    logic [pnig_pkg::DIM_W-1:0]        w_dec;
    logic [pnig_pkg::DIM_W-1:0]        h_dec;
    logic                              at_left, at_right, at_top, at_bottom;
    logic                              has_l, has_r, has_u, has_d, is_first, is_last;
    logic [pnig_pkg::NB_COUNT-1:0]     mask;

    // frame check against the registered area
    assign in_frame = pnig_pkg::CMP_W'(r_in_pix) < pnig_pkg::CMP_W'(i_geom.area);
    assign take     = (r_state == pnig_pkg::FS_IDLE);
    assign start    = take && r_in_valid && in_frame;
    assign div_last = (r_step == pnig_pkg::STEP_W'(pnig_pkg::DIV_STEPS - 1));

    // two restoring steps per cycle
    always_comb begin
        dvs_half = r_dvs >> 1;
        ge1      = (r_rem >= r_dvs);
        rem1     = ge1 ? (r_rem - r_dvs) : r_rem;
        ge2      = (rem1 >= dvs_half);
        rem2     = ge2 ? (rem1 - dvs_half) : rem1;
    end

    // classification of the column and row
    always_comb begin
        col       = r_rem[pnig_pkg::COORD_BITS-1:0];
        row       = r_quo[pnig_pkg::COORD_BITS-1:0];
        w_dec     = i_geom.width - pnig_pkg::DIM_W'(1);
        h_dec     = i_geom.height - pnig_pkg::DIM_W'(1);
        at_left   = (col == '0);
        at_right  = (col == w_dec[pnig_pkg::COORD_BITS-1:0]);
        at_top    = (row == '0);
        at_bottom = (row == h_dec[pnig_pkg::COORD_BITS-1:0]);
        has_l     = !at_left;
        has_r     = !at_right;
        has_u     = !at_top;
        has_d     = !at_bottom;
        is_first  = i_geom.wrap && at_left;
        is_last   = i_geom.wrap && at_right;

        mask                     = '0;
        mask[pnig_pkg::NB_LEFT]  = has_l;
        mask[pnig_pkg::NB_RIGHT] = has_r;
        mask[pnig_pkg::NB_UP]    = has_u;
        mask[pnig_pkg::NB_DOWN]  = has_d;
        mask[pnig_pkg::NB_FIRST] = is_first;
        mask[pnig_pkg::NB_LAST]  = is_last;
        mask[pnig_pkg::NB_UL]    = i_geom.eight && has_l && has_u;
        mask[pnig_pkg::NB_DL]    = i_geom.eight && has_l && has_d;
        mask[pnig_pkg::NB_UR]    = i_geom.eight && has_r && has_u;
        mask[pnig_pkg::NB_DR]    = i_geom.eight && has_r && has_d;
        mask[pnig_pkg::NB_FU]    = i_geom.eight && is_first && has_u;
        mask[pnig_pkg::NB_FD]    = i_geom.eight && is_first && has_d;
        mask[pnig_pkg::NB_LU]    = i_geom.eight && is_last && has_u;
        mask[pnig_pkg::NB_LD]    = i_geom.eight && is_last && has_d;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnig_pkg::FS_IDLE: begin
                if (start) begin
                    n_state = pnig_pkg::FS_DIV;
                end
            end
            pnig_pkg::FS_DIV: begin
                if (div_last) begin
                    n_state = pnig_pkg::FS_CLASS;
                end
            end
            pnig_pkg::FS_CLASS: begin
                if (!(|mask) || i_q_ready) begin
                    n_state = pnig_pkg::FS_IDLE;
                end
            end
            default: n_state = pnig_pkg::FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_ready     = !r_in_valid || take;
        o_q_valid     = (r_state == pnig_pkg::FS_CLASS) && (|mask);
        o_q_item.pix  = r_pix;
        o_q_item.mask = mask;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pnig_pkg::FS_IDLE;
            r_in_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_s_valid && o_s_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // input buffer and divider datapath
    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_in_pix <= i_s_pix;
        end
        if (start) begin
            r_pix  <= r_in_pix;
            r_rem  <= pnig_pkg::DIV_W'(r_in_pix);
            r_dvs  <= pnig_pkg::DIV_W'(i_geom.width) << (pnig_pkg::QUO_W - 1);
            r_quo  <= '0;
            r_step <= '0;
        end else if (r_state == pnig_pkg::FS_DIV) begin
            r_rem  <= rem2;
            r_dvs  <= r_dvs >> 2;
            r_quo  <= {r_quo[pnig_pkg::QUO_W-3:0], ge1, ge2};
            r_step <= r_step + pnig_pkg::STEP_W'(1);
        end
    end

endmodule

// ===== rtl/pnig_queue.sv =====
module pnig_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  pnig_pkg::t_item  i_push_item,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output pnig_pkg::t_item  o_pop_item
);

    pnig_pkg::t_item                r_mem [pnig_pkg::Q_DEPTH];
    logic [pnig_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [pnig_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [pnig_pkg::Q_CNT_W-1:0]   r_count;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_count != pnig_pkg::Q_CNT_W'(pnig_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + pnig_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + pnig_pkg::Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + pnig_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - pnig_pkg::Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== rtl/pnig_back.sv =====
module pnig_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pnig_pkg::t_geom                 i_geom,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  pnig_pkg::t_item                 i_q_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pnig_pkg::IDX_BITS-1:0]   o_index,
    output logic                            o_last
);

    pnig_pkg::t_item                   r_cur;
    logic                              r_cur_valid;
    logic                              r_out_valid;
    logic [pnig_pkg::IDX_BITS-1:0]     r_out_index;
    logic                              r_out_last;

    logic                              advance;
    logic                              emit;
    logic                              finish;
    pnig_pkg::t_nb                     sel;
    pnig_pkg::t_nb_ofs                 ofs;
    logic [pnig_pkg::NB_COUNT-1:0]     lowest;
    logic [pnig_pkg::NB_COUNT-1:0]     rest;
    logic [pnig_pkg::IDX_BITS-1:0]     w_one;
    logic [pnig_pkg::IDX_BITS-1:0]     w_term;
    logic [pnig_pkg::IDX_BITS-1:0]     p_term;
    logic [pnig_pkg::IDX_BITS-1:0]     nb_index;

    // lowest pending candidate
    always_comb begin
        sel = pnig_pkg::NB_LEFT;
        for (int i = pnig_pkg::NB_COUNT - 1; i >= 0; i--) begin
            if (r_cur.mask[i]) begin
                sel = pnig_pkg::t_nb'(pnig_pkg::NB_SEL_W'(i));
            end
        end
        lowest = r_cur.mask & (~r_cur.mask + pnig_pkg::NB_COUNT'(1));
        rest   = r_cur.mask & ~lowest;
    end

    // neighbor index from the offset table
    always_comb begin
        ofs   = pnig_pkg::nb_offset(sel);
        w_one = pnig_pkg::IDX_BITS'(i_geom.width);
        unique case (ofs.w_mag)
            2'd1:    w_term = w_one;
            2'd2:    w_term = w_one << 1;
            default: w_term = '0;
        endcase
        unique case (ofs.px)
            pnig_pkg::PX_INC: p_term = pnig_pkg::IDX_BITS'(1);
            pnig_pkg::PX_DEC: p_term = '1;
            default:          p_term = '0;
        endcase
        nb_index = r_cur.pix + (ofs.w_neg ? (~w_term + pnig_pkg::IDX_BITS'(1)) : w_term)
                 + p_term;
    end

    assign advance   = !r_out_valid || i_ready;
    assign emit      = r_cur_valid && advance;
    assign finish    = emit && (rest == '0);
    assign o_q_ready = !r_cur_valid || finish;
    assign o_valid   = r_out_valid;
    assign o_index   = r_out_index;
    assign o_last    = r_out_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_q_valid && o_q_ready) begin
                r_cur_valid <= 1'b1;
            end else if (finish) begin
                r_cur_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_cur_valid;
            end
        end
    end

    // current pixel and output register
    always_ff @(posedge i_clk) begin
        if (i_q_valid && o_q_ready) begin
            r_cur <= i_q_item;
        end else if (emit) begin
            r_cur.mask <= rest;
        end
        if (emit) begin
            r_out_index <= nb_index;
            r_out_last  <= (rest == '0);
        end
    end

endmodule

// ===== rtl/pixel_neighbor_index_generator_unit.sv =====
// Pixel neighbor index generator: each pixel_index transaction (row * width
// + column) yields the linear indices of its in-frame neighbors, one per output
// transaction, tlast on the final one: left, right, up, down, the horizontal wrap
// partners when wrap_columns is set, then with eight_connected the four
// diagonals and the wrap diagonals. An index outside the frame, or a pixel with
// no neighbor, gives no output. The front end takes a pixel from the input
// buffer, splits it into column and row with DIV_STEPS = 6 steps of the radix-4
// divider and classifies it, holding while the queue is full; an out-of-frame
// pixel is dropped. The back end delivers one neighbor per cycle unless the
// output stalls, up to 8 per pixel, behind a 4-entry queue and an output
// register; the front end takes no new pixel until the last is classified, so
// the divider sets the rate. The user must write configuration only while no
// pixel is in flight; the block does not enforce it; no clearing pass follows reset.
module pixel_neighbor_index_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pnig_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pnig_pkg::CFG_DIM_W-1:0]   i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [23:0]                      i_s_axis_tdata,   // [23:0] pixel_index
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [23:0]                      o_m_axis_tdata,   // [23:0] neighbor_index
    output logic                             o_m_axis_tlast    // last_neighbor
);

    logic [pnig_pkg::DIM_W-1:0]    r_width;
    logic [pnig_pkg::DIM_W-1:0]    r_height;
    logic [pnig_pkg::AREA_W-1:0]   r_area;
    logic                          r_wrap;
    logic                          r_eight;

    pnig_pkg::t_geom               geom;
    logic                          q_push_valid;
    logic                          q_push_ready;
    pnig_pkg::t_item               q_push_item;
    logic                          q_pop_valid;
    logic                          q_pop_ready;
    pnig_pkg::t_item               q_pop_item;

    assign o_cfg_ready = 1'b1;

    // configuration registers, dimensions stored saturated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pnig_pkg::DIM_W'(1);
            r_height <= pnig_pkg::DIM_W'(1);
            r_wrap   <= 1'b0;
            r_eight  <= 1'b0;
            r_area   <= pnig_pkg::AREA_W'(1);
        end else begin
            r_area <= pnig_pkg::AREA_W'(r_width) * pnig_pkg::AREA_W'(r_height);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (pnig_pkg::t_cfg_reg'(i_cfg_index))
                    pnig_pkg::CFG_WIDTH:  r_width  <= pnig_pkg::clamp_dim(i_cfg_data);
                    pnig_pkg::CFG_HEIGHT: r_height <= pnig_pkg::clamp_dim(i_cfg_data);
                    pnig_pkg::CFG_WRAP:   r_wrap   <= i_cfg_data[0];
                    pnig_pkg::CFG_EIGHT:  r_eight  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        geom.width  = r_width;
        geom.height = r_height;
        geom.area   = r_area;
        geom.wrap   = r_wrap;
        geom.eight  = r_eight;
    end

    // divide and classify
    pnig_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_pix   (i_s_axis_tdata),
        .o_q_valid (q_push_valid),
        .i_q_ready (q_push_ready),
        .o_q_item  (q_push_item)
    );

    // decoupling queue
    pnig_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_item  (q_push_item),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_item   (q_pop_item)
    );

    // neighbor emission
    pnig_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_valid (q_pop_valid),
        .o_q_ready (q_pop_ready),
        .i_q_item  (q_pop_item),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_index   (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== rtl/pnig_checker.sv =====
module pnig_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_s_axis_tready,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [23:0]                      o_m_axis_tdata,
    input  logic                             o_m_axis_tlast
);

    // a stalled output transaction holds its index and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output transaction changed while stalled");

    // the input buffer is empty right after reset
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_s_axis_tready)
        else $error("input not ready after reset");

    // the pipeline is empty right after reset
    a_no_out_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output transaction right after reset");

    // no output transaction while reset is still seen in the assertion's past window
    a_no_out_two_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n, 2) |-> !o_m_axis_tvalid)
        else $error("output transaction too soon after reset");

endmodule

bind pixel_neighbor_index_generator_unit pnig_checker u_pnig_checker (.*);
